// ----- hw/rtl/ffba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the first-fit block allocator.
// Used by the RAM-facing datapath, the controller and the top level.
package ffba_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int HEADER_BYTES   = 24;
    localparam int ADDR_W         = 32;
    localparam int SUM_W          = ADDR_W + 2;
    localparam int IDX_W          = $clog2(MAX_BLOCKS);
    localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
    localparam int IN_TDATA_W     = 72;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'd4096;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_OOM     = 2'd2,
        ST_BADFREE = 2'd3
    } status_t;

    typedef enum logic {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic              is_free;
        logic [ADDR_W-1:0] bytes;
        logic [ADDR_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trivial;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/ffba_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; depends on nothing else in the project.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ffba_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the allocator: block table RAM, scan pointer, break and limit
// registers, result logic and output register. Depends on ffba_pkg and ffba_ram.
module ffba_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffba_pkg::mode_t              in_mode,
    input  logic [ffba_pkg::ADDR_W-1:0]  in_request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]  in_release_address,
    input  logic                         cfg_we,
    input  ffba_pkg::cfg_index_t         cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]  cfg_wdata,
    input  ffba_pkg::ctrl_cmd_t          cmd,
    output ffba_pkg::dp_status_t         status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffba_pkg::ADDR_W-1:0]  out_data_address,
    output ffba_pkg::status_t            out_status,
    output logic                         out_reused
);

    import ffba_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [ADDR_W-1:0]  req_reg, req_next;
    logic [ADDR_W-1:0]  rel_reg, rel_next;
    logic [SUM_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  break_reg, break_next;
    logic [ADDR_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    entry_t             hit_entry_reg, hit_entry_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    status_t            out_status_reg, out_status_next;
    logic               out_reused_reg, out_reused_next;

    entry_t             rd_entry;
    logic [$bits(entry_t)-1:0] rd_word;
    logic               issue;
    logic               trivial;
    logic               match_alloc;
    logic               match_free;
    logic               scan_hit;

    logic [ADDR_W-1:0]  res_addr;
    status_t            res_status;
    logic               res_reused;
    logic               wr_req;
    logic               append;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;

    ffba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.commit && wr_req),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    assign issue = cmd.scan && (idx_reg < count_reg);
    assign trivial = (mode_reg == MODE_ALLOC) ? (req_reg == '0) : (rel_reg == '0);
    assign match_alloc = rd_entry.is_free && (rd_entry.bytes >= req_reg);
    assign match_free = (({1'b0, rd_entry.start} + (ADDR_W+1)'(HEADER_BYTES))
                        == {1'b0, rel_reg});
    assign scan_hit = pend_reg && !trivial &&
                      ((mode_reg == MODE_ALLOC) ? match_alloc : match_free);

    assign status.trivial  = trivial;
    assign status.scan_hit = scan_hit;
    assign status.scan_end = !pend_reg && (idx_reg == count_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        res_addr   = '0;
        res_status = ST_OK;
        res_reused = 1'b0;
        wr_req     = 1'b0;
        append     = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_entry   = hit_entry_reg;
        case (mode_reg)
            MODE_ALLOC:
            begin
                if (req_reg == '0)
                begin
                    res_status = ST_ZERO;
                end
                else if (hit_reg)
                begin
                    res_addr         = hit_entry_reg.start + ADDR_W'(HEADER_BYTES);
                    res_reused       = 1'b1;
                    wr_req           = 1'b1;
                    wr_entry.is_free = 1'b0;
                end
                else if (count_reg == CNT_W'(MAX_BLOCKS))
                begin
                    res_status = ST_OOM;
                end
                else if (end_reg > {2'b00, limit_reg})
                begin
                    res_status = ST_OOM;
                end
                else
                begin
                    res_addr         = break_reg + ADDR_W'(HEADER_BYTES);
                    wr_req           = 1'b1;
                    append           = 1'b1;
                    wr_addr          = count_reg[IDX_W-1:0];
                    wr_entry.is_free = 1'b0;
                    wr_entry.bytes   = req_reg;
                    wr_entry.start   = break_reg;
                end
            end
            default:
            begin
                if (rel_reg == '0)
                begin
                    res_status = ST_OK;
                end
                else if (hit_reg && !hit_entry_reg.is_free)
                begin
                    wr_req           = 1'b1;
                    wr_entry.is_free = 1'b1;
                end
                else
                begin
                    res_status = ST_BADFREE;
                end
            end
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        req_next        = req_reg;
        rel_next        = rel_reg;
        end_next        = end_reg;
        count_next      = count_reg;
        break_next      = break_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_reused_next = out_reused_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            mode_next = in_mode;
            req_next  = in_request_bytes;
            rel_next  = in_release_address;
            end_next  = {2'b00, break_reg} + {2'b00, in_request_bytes}
                        + SUM_W'(HEADER_BYTES);
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (scan_hit)
            begin
                hit_next       = 1'b1;
                hit_idx_next   = hit_idx_reg;
                hit_entry_next = rd_entry;
            end
        end

        if (cmd.commit)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr;
            out_status_next = res_status;
            out_reused_next = res_reused;
            if (append)
            begin
                count_next = count_reg + CNT_W'(1);
                break_next = end_reg[ADDR_W-1:0];
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAP_BASE:
                begin
                    if (count_reg == '0)
                    begin
                        break_next = cfg_wdata;
                    end
                end
                REG_HEAP_LIMIT:
                begin
                    limit_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The index of the word in flight is registered from the read address when a read is issued.
    logic [IDX_W-1:0] rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        end
        mode_reg       <= mode_next;
        req_reg        <= req_next;
        rel_reg        <= rel_next;
        end_reg        <= end_next;
        hit_idx_reg    <= (cmd.scan && scan_hit) ? rd_idx_reg : hit_idx_next;
        hit_entry_reg  <= hit_entry_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_reused_reg <= out_reused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            break_reg     <= HEAP_BASE_RESET;
            limit_reg     <= HEAP_LIMIT_RESET;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            break_reg     <= break_next;
            limit_reg     <= limit_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data_address = out_addr_reg;
    assign out_status       = out_status_reg;
    assign out_reused       = out_reused_reg;

endmodule

// ----- hw/rtl/ffba_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the allocator: sequences load, table scan and
// commit of one transaction. Depends on ffba_pkg.
module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffba_pkg::dp_status_t status,
    output ffba_pkg::ctrl_cmd_t  cmd
);

    import ffba_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.trivial || status.scan_hit || status.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: stream ports, configuration
// port, controller and datapath. Depends on ffba_pkg, ffba_ctrl, ffba_datapath.
//
// Each input transaction is one request: allocate a number of bytes, or free
// a data address. Each request gives exactly one output transaction with the
// granted data address, a status code and a reuse flag.
// The block handles one request at a time. An allocate scans the block table
// from the oldest entry, one RAM read per cycle, and stops at the first fit;
// a free scans for the matching address in the same way. The table RAM has a
// registered read port. A zero-size allocate, a null free or an empty table
// ends the scan at once and goes straight to the commit step. A new request
// can be accepted in the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds the block
// in its commit step, with no table change, until the register is free.
// Reset empties the table, sets the break to 4096 and the limit to 1048576.
// Configuration writes must be made only while no request is in flight.
module first_fit_block_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: mode, request_bytes, release_address, zero fill.
    input  logic [ffba_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: data_address, status, reused, zero fill.
    output logic [ffba_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_we,
    input  ffba_pkg::cfg_index_t                 cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]          cfg_wdata
);

    import ffba_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [ADDR_W-1:0] out_addr;
    status_t           out_status;
    logic              out_reused;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffba_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_mode            (mode_t'(s_axis_tdata[0])),
        .in_request_bytes   (s_axis_tdata[ADDR_W:1]),
        .in_release_address (s_axis_tdata[2*ADDR_W:ADDR_W+1]),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .out_data_address   (out_addr),
        .out_status         (out_status),
        .out_reused         (out_reused)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-ADDR_W-3)'(0), out_reused, out_status, out_addr};

endmodule

// ----- verif/tb_first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_block_allocator: random allocate and free traffic
// with stalls on both streams, checked against a behavioral model of the block table.
// Depends on ffba_pkg and the allocator RTL.
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] release_address;
        logic [ADDR_W-1:0] request_bytes;
        mode_t             mode;
    } request_t;

    typedef struct packed {
        logic              reused;
        status_t           status;
        logic [ADDR_W-1:0] data_address;
    } grant_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [ADDR_W-1:0]      cfg_wdata;

    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_bytes [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_count;
    logic [ADDR_W-1:0] break_ptr;
    logic [ADDR_W-1:0] limit_reg;

    request_t pending_requests[$];
    grant_t   awaited_grants[$];
    logic     in_fire;
    int       send_gap;
    int       sink_wait;
    bit       steady_flow;
    bit       hold_armed;
    int       fault_count;

    first_fit_block_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // Applies one request to the table model and returns the grant it produces.
    function automatic grant_t predict_grant(request_t rq);
        grant_t      g;
        logic [63:0] span_end;
        int          slot;
        int          i;
        g.reused       = 1'b0;
        g.status       = ST_OK;
        g.data_address = '0;
        slot           = -1;
        if (rq.mode == MODE_ALLOC)
        begin
            if (rq.request_bytes == '0)
            begin
                g.status = ST_ZERO;
                return g;
            end
            for (i = 0; i < blk_count; i++)
                if (slot < 0 && blk_free[i] && blk_bytes[i] >= rq.request_bytes)
                    slot = i;
            if (slot >= 0)
            begin
                blk_free[slot] = 1'b0;
                g.reused       = 1'b1;
                g.data_address = blk_start[slot] + ADDR_W'(HEADER_BYTES);
                return g;
            end
            span_end = 64'(break_ptr) + 64'(rq.request_bytes) + 64'(HEADER_BYTES);
            if (blk_count >= MAX_BLOCKS || span_end > 64'(limit_reg))
            begin
                g.status = ST_OOM;
                return g;
            end
            blk_start[blk_count] = break_ptr;
            blk_bytes[blk_count] = rq.request_bytes;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            g.data_address = break_ptr + ADDR_W'(HEADER_BYTES);
            break_ptr      = span_end[ADDR_W-1:0];
            return g;
        end
        if (rq.release_address == '0)
            return g;
        for (i = 0; i < blk_count; i++)
            if (slot < 0 && 64'(blk_start[i]) + 64'(HEADER_BYTES) == 64'(rq.release_address))
                slot = i;
        if (slot < 0 || blk_free[slot])
            g.status = ST_BADFREE;
        else
            blk_free[slot] = 1'b1;
        return g;
    endfunction

    task automatic note_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HEAP_BASE)
        begin
            if (blk_count == 0)
                break_ptr = value;
        end
        else
            limit_reg = value;
    endtask

    task automatic push_request(mode_t m, logic [ADDR_W-1:0] bytes, logic [ADDR_W-1:0] addr);
        pending_requests.push_back('{release_address: addr, request_bytes: bytes, mode: m});
    endtask

    // Frees mostly target granted blocks that look in use, so the table sees real reuse.
    task automatic feed_random(int count, int alloc_pct, int wide_pct);
        request_t rq;
        int       pick;
        int       tries;
        int       idx;
        repeat (count)
        begin
            while (pending_requests.size() >= 4)
                @(posedge clk);
            #1;
            rq.request_bytes   = $urandom();
            rq.release_address = $urandom();
            pick               = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                rq.mode = MODE_ALLOC;
                if (pick < wide_pct)
                    rq.request_bytes = $urandom();
                else if (pick < wide_pct + 8)
                    rq.request_bytes = '0;
                else if (pick < wide_pct + 18)
                    rq.request_bytes = $urandom_range(201, 5000);
                else
                    rq.request_bytes = $urandom_range(1, 200);
            end
            else
            begin
                rq.mode = MODE_FREE;
                if (pick < 8)
                    rq.release_address = '0;
                else if (pick >= 22 && blk_count > 0)
                begin
                    tries = 0;
                    do
                    begin
                        idx = $urandom_range(0, blk_count - 1);
                        tries++;
                    end
                    while (blk_free[idx] && tries < 4);
                    rq.release_address = blk_start[idx] + ADDR_W'(HEADER_BYTES);
                    if (pick < 34)
                    begin
                        if ($urandom_range(0, 1))
                            rq.release_address = rq.release_address + $urandom_range(1, 4);
                        else
                            rq.release_address = rq.release_address - $urandom_range(1, 4);
                    end
                end
            end
            pending_requests.push_back(rq);
        end
    endtask

    task automatic settle();
        while (pending_requests.size() > 0 || s_axis_tvalid || awaited_grants.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n && !(s_axis_tvalid && !in_fire))
        begin
            if (s_axis_tvalid)
                send_gap = (steady_flow || $urandom_range(0, 99) < 65) ? 0 : idle_len();
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                nxt = pending_requests.pop_front();
                s_axis_tdata  <= {{(IN_TDATA_W - $bits(request_t)){1'b0}}, nxt};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                sink_wait  = 400;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else if (steady_flow || $urandom_range(0, 99) < 70)
                m_axis_tready <= 1'b1;
            else
            begin
                sink_wait = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            awaited_grants.push_back(predict_grant(request_t'(s_axis_tdata[$bits(request_t)-1:0])));
    end

    always @(posedge clk)
    begin
        grant_t seen;
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = grant_t'(m_axis_tdata[$bits(grant_t)-1:0]);
            if (awaited_grants.size() == 0)
                note_fault($sformatf("unexpected transaction: addr=%h status=%0d reused=%b",
                                     seen.data_address, seen.status, seen.reused));
            else
            begin
                want = awaited_grants.pop_front();
                if (seen.data_address !== want.data_address || seen.status !== want.status ||
                    seen.reused !== want.reused)
                    note_fault($sformatf({"grant mismatch: expected addr=%h status=%0d reused=%b,",
                                          " got addr=%h status=%0d reused=%b"},
                                         want.data_address, want.status, want.reused,
                                         seen.data_address, seen.status, seen.reused));
            end
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] b;
        longint            span;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_HEAP_BASE;
        cfg_wdata     = '0;
        steady_flow   = 1'b0;
        hold_armed    = 1'b0;
        send_gap      = 0;
        sink_wait     = 0;
        fault_count   = 0;
        blk_count     = 0;
        limit_reg     = HEAP_LIMIT_RESET;
        break_ptr     = HEAP_BASE_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Break parked at the top of the address space: every append overflows the limit.
        write_reg(REG_HEAP_BASE, '1);
        write_reg(REG_HEAP_LIMIT, '1);
        push_request(MODE_ALLOC, 32'd1, '0);
        push_request(MODE_ALLOC, '0, '1);
        push_request(MODE_ALLOC, '1, '0);
        push_request(MODE_FREE, '1, '0);
        push_request(MODE_FREE, '0, '1);
        settle();

        write_reg(REG_HEAP_BASE, 32'd1);
        write_reg(REG_HEAP_LIMIT, 32'd1);
        push_request(MODE_ALLOC, 32'd1, '0);
        push_request(MODE_FREE, '0, 32'd25);
        settle();

        b = $urandom_range(1, 32'hF000_0000);
        write_reg(REG_HEAP_BASE, b);
        write_reg(REG_HEAP_LIMIT, b + 32'd4000);
        push_request(MODE_ALLOC, 32'd100, '0);
        push_request(MODE_ALLOC, 32'd50, '0);
        push_request(MODE_FREE, '0, b + 32'd24);
        push_request(MODE_FREE, '0, b + 32'd24);
        push_request(MODE_FREE, '0, b + 32'd25);
        push_request(MODE_ALLOC, 32'd100, '0);
        push_request(MODE_ALLOC, 32'd101, '0);
        push_request(MODE_FREE, '0, b + 32'd148);
        push_request(MODE_ALLOC, 32'd40, '0);
        push_request(MODE_ALLOC, 32'd60, '0);
        push_request(MODE_FREE, '1, '0);
        push_request(MODE_ALLOC, '0, '1);
        settle();

        feed_random(450, 55, 10);
        settle();

        // One byte past the limit, then an exact fit up to it.
        span = longint'(limit_reg) - longint'(break_ptr) - HEADER_BYTES;
        if (span > 0 && blk_count < MAX_BLOCKS)
        begin
            push_request(MODE_ALLOC, ADDR_W'(span + 1), '0);
            push_request(MODE_ALLOC, ADDR_W'(span), '0);
        end
        settle();

        write_reg(REG_HEAP_LIMIT, '1);
        write_reg(REG_HEAP_BASE, $urandom());
        feed_random(450, 60, 0);
        settle();

        steady_flow = 1'b1;
        hold_armed  = 1'b1;
        feed_random(60, 55, 0);
        settle();
        steady_flow = 1'b0;

        write_reg(REG_HEAP_LIMIT, 32'd1);
        write_reg(REG_HEAP_BASE, 32'd1);
        feed_random(380, 55, 10);
        settle();

        repeat (80) @(posedge clk);
        if (fault_count == 0 && awaited_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
